/* src/scsi_rw_command_block_builder_defines.svh */
// assertion macros shared by the command block builder rtl
`ifndef SCSI_RW_COMMAND_BLOCK_BUILDER_DEFINES_SVH
`define SCSI_RW_COMMAND_BLOCK_BUILDER_DEFINES_SVH

// checked on every clock edge, skipped while reset is held
`define SCSIRW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define SCSIRW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/scsirw_pkg.sv */
// types, opcodes and error codes for the scsi read/write command block builder
package scsirw_pkg;

  localparam logic [4:0] LEN_6  = 5'd6;
  localparam logic [4:0] LEN_10 = 5'd10;
  localparam logic [4:0] LEN_12 = 5'd12;
  localparam logic [4:0] LEN_16 = 5'd16;
  localparam logic [4:0] LEN_RESET = LEN_10;

  localparam logic [7:0] OP_READ_6   = 8'h08;
  localparam logic [7:0] OP_READ_10  = 8'h28;
  localparam logic [7:0] OP_READ_12  = 8'ha8;
  localparam logic [7:0] OP_READ_16  = 8'h88;
  localparam logic [7:0] OP_WRITE_6  = 8'h0a;
  localparam logic [7:0] OP_WRITE_10 = 8'h2a;
  localparam logic [7:0] OP_WRITE_12 = 8'haa;
  localparam logic [7:0] OP_WRITE_16 = 8'h8a;

  localparam logic [32:0] SIX_MAX_LBA   = 33'h1fffff;
  localparam logic [31:0] SIX_MAX_COUNT = 32'd256;
  localparam logic [31:0] TEN_MAX_COUNT = 32'h0000ffff;
  localparam logic [7:0]  DPO_BIT = 8'h10;
  localparam logic [7:0]  FUA_BIT = 8'h08;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_BAD_LEN   = 3'd1,
    ERR_COUNT     = 3'd2,
    ERR_REACH     = 3'd3,
    ERR_SIX_FLAGS = 3'd4
  } err_code_t;

  typedef struct packed {
    logic [31:0] start_lba;
    logic [31:0] block_count;
    logic        is_write;
    logic        force_unit_access;
    logic        disable_page_out;
  } req_t;

  typedef struct packed {
    logic [63:0] cdb_low_bytes;
    logic [63:0] cdb_high_bytes;
    logic [4:0]  cdb_length;
    err_code_t   error_code;
  } cdb_res_t;

endpackage

/* src/scsirw_if.sv */
// valid/ready channel interfaces for requests, command blocks and configuration
interface scsirw_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_lba;
  logic [31:0] block_count;
  logic        is_write;
  logic        force_unit_access;
  logic        disable_page_out;

  modport source (output valid, output start_lba, output block_count, output is_write,
                  output force_unit_access, output disable_page_out, input ready);
  modport sink (input valid, input start_lba, input block_count, input is_write,
                input force_unit_access, input disable_page_out, output ready);
endinterface

interface scsirw_cdb_if;
  logic        valid;
  logic        ready;
  logic [63:0] cdb_low_bytes;
  logic [63:0] cdb_high_bytes;
  logic [4:0]  cdb_length;
  logic [2:0]  error_code;

  modport source (output valid, output cdb_low_bytes, output cdb_high_bytes,
                  output cdb_length, output error_code, input ready);
  modport sink (input valid, input cdb_low_bytes, input cdb_high_bytes,
                input cdb_length, input error_code, output ready);
endinterface

interface scsirw_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] command_length;

  modport source (output valid, output command_length, input ready);
  modport sink (input valid, input command_length, output ready);
endinterface

/* src/scsirw_encode.sv */
// combinational packing and checking of one read/write command block
module scsirw_encode (
  input  logic [4:0]          cmd_len,
  input  scsirw_pkg::req_t    req,
  output scsirw_pkg::cdb_res_t res
);

  logic [7:0]  b [16];
  logic [7:0]  flags;
  logic [31:0] cnt_m1;
  logic [32:0] last_lba;
  logic [63:0] lo;
  logic [63:0] hi;
  scsirw_pkg::err_code_t err;

  assign flags = (req.disable_page_out ? scsirw_pkg::DPO_BIT : 8'h00) |
                 (req.force_unit_access ? scsirw_pkg::FUA_BIT : 8'h00);
  assign cnt_m1 = (req.block_count == 32'd0) ? 32'd0 : req.block_count - 32'd1;
  assign last_lba = {1'b0, req.start_lba} + {1'b0, cnt_m1};

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      b[i] = 8'h00;
    end
    err = scsirw_pkg::ERR_OK;
    case (cmd_len)
      scsirw_pkg::LEN_6: begin
        b[0] = req.is_write ? scsirw_pkg::OP_WRITE_6 : scsirw_pkg::OP_READ_6;
        b[1] = {3'b000, req.start_lba[20:16]};
        b[2] = req.start_lba[15:8];
        b[3] = req.start_lba[7:0];
        // a count of 256 wraps to zero here
        b[4] = req.block_count[7:0];
        if (req.block_count > scsirw_pkg::SIX_MAX_COUNT) begin
          err = scsirw_pkg::ERR_COUNT;
        end else if (last_lba > scsirw_pkg::SIX_MAX_LBA) begin
          err = scsirw_pkg::ERR_REACH;
        end else if (req.disable_page_out || req.force_unit_access) begin
          err = scsirw_pkg::ERR_SIX_FLAGS;
        end
      end
      scsirw_pkg::LEN_10: begin
        b[0] = req.is_write ? scsirw_pkg::OP_WRITE_10 : scsirw_pkg::OP_READ_10;
        b[1] = flags;
        b[2] = req.start_lba[31:24];
        b[3] = req.start_lba[23:16];
        b[4] = req.start_lba[15:8];
        b[5] = req.start_lba[7:0];
        b[7] = req.block_count[15:8];
        b[8] = req.block_count[7:0];
        if (req.block_count > scsirw_pkg::TEN_MAX_COUNT) begin
          err = scsirw_pkg::ERR_COUNT;
        end
      end
      scsirw_pkg::LEN_12: begin
        b[0] = req.is_write ? scsirw_pkg::OP_WRITE_12 : scsirw_pkg::OP_READ_12;
        b[1] = flags;
        b[2] = req.start_lba[31:24];
        b[3] = req.start_lba[23:16];
        b[4] = req.start_lba[15:8];
        b[5] = req.start_lba[7:0];
        b[6] = req.block_count[31:24];
        b[7] = req.block_count[23:16];
        b[8] = req.block_count[15:8];
        b[9] = req.block_count[7:0];
      end
      scsirw_pkg::LEN_16: begin
        b[0]  = req.is_write ? scsirw_pkg::OP_WRITE_16 : scsirw_pkg::OP_READ_16;
        b[1]  = flags;
        b[6]  = req.start_lba[31:24];
        b[7]  = req.start_lba[23:16];
        b[8]  = req.start_lba[15:8];
        b[9]  = req.start_lba[7:0];
        b[10] = req.block_count[31:24];
        b[11] = req.block_count[23:16];
        b[12] = req.block_count[15:8];
        b[13] = req.block_count[7:0];
      end
      default: begin
        err = scsirw_pkg::ERR_BAD_LEN;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = b[i];
      hi[8*i +: 8] = b[i+8];
    end
  end

  always_comb begin
    res.error_code = err;
    if (err == scsirw_pkg::ERR_OK) begin
      res.cdb_low_bytes  = lo;
      res.cdb_high_bytes = hi;
      res.cdb_length     = cmd_len;
    end else begin
      res.cdb_low_bytes  = 64'd0;
      res.cdb_high_bytes = 64'd0;
      res.cdb_length     = 5'd0;
    end
  end

endmodule

/* src/scsi_rw_command_block_builder.sv */
// top level of the scsi read/write command block builder
//
//  channel  | direction | beat carries
//  in_ch    | sink      | start_lba, block_count, is_write, force_unit_access, disable_page_out
//  out_ch   | source    | cdb_low_bytes, cdb_high_bytes, cdb_length, error_code
//  cfg_ch   | sink      | command_length
//
// an input beat passes through the input register, then the packing logic into the
// result register. one beat per cycle is sustained while out_ch is not stalled.
// rst_n is synchronous; it empties both stages and sets command_length to 10.
// a stall on out_ch holds the result register, and the input register keeps taking
// a beat while it is empty; cfg_ch is always ready.
`include "scsi_rw_command_block_builder_defines.svh"

module scsi_rw_command_block_builder (
  input  logic         clk,
  input  logic         rst_n,
  scsirw_req_if.sink   in_ch,
  scsirw_cdb_if.source out_ch,
  scsirw_cfg_if.sink   cfg_ch
);

  logic [4:0]           cmd_len_r;
  logic                 s1_v_r;
  scsirw_pkg::req_t     s1_req_r;
  logic                 out_v_r;
  scsirw_pkg::cdb_res_t out_res_r;
  scsirw_pkg::cdb_res_t res_nxt;
  logic                 advance;
  logic                 in_fire;

  assign advance = !out_v_r || out_ch.ready;
  assign in_ch.ready = !s1_v_r || advance;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_len_r <= scsirw_pkg::LEN_RESET;
    end else if (cfg_ch.valid) begin
      cmd_len_r <= cfg_ch.command_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.start_lba         <= in_ch.start_lba;
      s1_req_r.block_count       <= in_ch.block_count;
      s1_req_r.is_write          <= in_ch.is_write;
      s1_req_r.force_unit_access <= in_ch.force_unit_access;
      s1_req_r.disable_page_out  <= in_ch.disable_page_out;
    end
    if (advance && s1_v_r) begin
      out_res_r <= res_nxt;
    end
  end

  scsirw_encode u_encode (
    .cmd_len (cmd_len_r),
    .req     (s1_req_r),
    .res     (res_nxt)
  );

  assign out_ch.valid          = out_v_r;
  assign out_ch.cdb_low_bytes  = out_res_r.cdb_low_bytes;
  assign out_ch.cdb_high_bytes = out_res_r.cdb_high_bytes;
  assign out_ch.cdb_length     = out_res_r.cdb_length;
  assign out_ch.error_code     = out_res_r.error_code;

  `SCSIRW_ASSERT(a_err_clears_cdb,
    out_v_r && (out_res_r.error_code != scsirw_pkg::ERR_OK) |->
      (out_res_r.cdb_low_bytes == 64'd0) && (out_res_r.cdb_high_bytes == 64'd0) &&
      (out_res_r.cdb_length == 5'd0),
    "error result carries command bytes or a length")
  `SCSIRW_ASSERT(a_ok_len_legal,
    out_v_r && (out_res_r.error_code == scsirw_pkg::ERR_OK) |->
      (out_res_r.cdb_length == scsirw_pkg::LEN_6) ||
      (out_res_r.cdb_length == scsirw_pkg::LEN_10) ||
      (out_res_r.cdb_length == scsirw_pkg::LEN_12) ||
      (out_res_r.cdb_length == scsirw_pkg::LEN_16),
    "good result with an illegal command length")
  `SCSIRW_ASSERT(a_stage_moves,
    s1_v_r && advance |=> out_v_r,
    "input stage beat lost on its way to the result register")
  `SCSIRW_ASSERT(a_ready_when_empty,
    !out_v_r |-> in_ch.ready,
    "input not ready while the result register is empty")
  `SCSIRW_ASSERT_ALWAYS(a_reset_empties,
    !rst_n |=> !s1_v_r && !out_v_r,
    "pipeline holds a beat after reset")

endmodule

/* test/testbench.sv */
// testbench for the scsi read/write command block builder with a built-in predictor
`timescale 1ns / 1ps

module testbench;

  logic clk = 1'b0;
  logic rst_n;

  scsirw_req_if req_ch();
  scsirw_cdb_if cdb_ch();
  scsirw_cfg_if cfg_ch();

  scsi_rw_command_block_builder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (cdb_ch),
    .cfg_ch (cfg_ch)
  );

  scsirw_pkg::req_t     req_backlog[$];
  scsirw_pkg::cdb_res_t cdb_due[$];
  logic [4:0] cmd_len = scsirw_pkg::LEN_RESET;
  logic       req_fire = 1'b0;
  logic       rx_hold = 1'b0;
  logic       stall_go = 1'b0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         n_queued = 0;
  int         n_accepted = 0;
  int         n_err = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic scsirw_pkg::cdb_res_t build_cdb(scsirw_pkg::req_t r, logic [4:0] len);
    logic [7:0]  b [16];
    logic [7:0]  flags;
    logic [32:0] last_blk;
    scsirw_pkg::err_code_t err;
    scsirw_pkg::cdb_res_t  res;
    for (int i = 0; i < 16; i++) b[i] = 8'h00;
    flags = (r.disable_page_out ? scsirw_pkg::DPO_BIT : 8'h00) |
            (r.force_unit_access ? scsirw_pkg::FUA_BIT : 8'h00);
    err = scsirw_pkg::ERR_OK;
    case (len)
      scsirw_pkg::LEN_6: begin
        b[0] = r.is_write ? scsirw_pkg::OP_WRITE_6 : scsirw_pkg::OP_READ_6;
        b[1] = {3'b000, r.start_lba[20:16]};
        b[2] = r.start_lba[15:8];
        b[3] = r.start_lba[7:0];
        b[4] = (r.block_count == scsirw_pkg::SIX_MAX_COUNT) ? 8'h00 : r.block_count[7:0];
        last_blk = {1'b0, r.start_lba} +
                   ((r.block_count == 32'd0) ? 33'd0 : {1'b0, r.block_count} - 33'd1);
        if (r.block_count > scsirw_pkg::SIX_MAX_COUNT) err = scsirw_pkg::ERR_COUNT;
        else if (last_blk > scsirw_pkg::SIX_MAX_LBA) err = scsirw_pkg::ERR_REACH;
        else if (r.disable_page_out || r.force_unit_access) err = scsirw_pkg::ERR_SIX_FLAGS;
      end
      scsirw_pkg::LEN_10: begin
        b[0] = r.is_write ? scsirw_pkg::OP_WRITE_10 : scsirw_pkg::OP_READ_10;
        b[1] = flags;
        for (int i = 0; i < 4; i++) b[2 + i] = r.start_lba[31 - 8 * i -: 8];
        b[7] = r.block_count[15:8];
        b[8] = r.block_count[7:0];
        if (r.block_count > scsirw_pkg::TEN_MAX_COUNT) err = scsirw_pkg::ERR_COUNT;
      end
      scsirw_pkg::LEN_12: begin
        b[0] = r.is_write ? scsirw_pkg::OP_WRITE_12 : scsirw_pkg::OP_READ_12;
        b[1] = flags;
        for (int i = 0; i < 4; i++) begin
          b[2 + i] = r.start_lba[31 - 8 * i -: 8];
          b[6 + i] = r.block_count[31 - 8 * i -: 8];
        end
      end
      scsirw_pkg::LEN_16: begin
        b[0] = r.is_write ? scsirw_pkg::OP_WRITE_16 : scsirw_pkg::OP_READ_16;
        b[1] = flags;
        for (int i = 0; i < 4; i++) begin
          b[6 + i] = r.start_lba[31 - 8 * i -: 8];
          b[10 + i] = r.block_count[31 - 8 * i -: 8];
        end
      end
      default: err = scsirw_pkg::ERR_BAD_LEN;
    endcase
    res = '0;
    res.error_code = err;
    if (err == scsirw_pkg::ERR_OK) begin
      for (int i = 0; i < 8; i++) begin
        res.cdb_low_bytes[8 * i +: 8] = b[i];
        res.cdb_high_bytes[8 * i +: 8] = b[i + 8];
      end
      res.cdb_length = len;
    end
    return res;
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hff;
      3: return 32'h100;
      4: return 32'h101;
      5: return 32'hffff;
      6: return 32'h10000;
      7: return 32'h1fffff;
      8: return 32'h200000;
      default: return 32'hffffffff;
    endcase
  endfunction

  function automatic scsirw_pkg::req_t random_req(logic [4:0] len);
    scsirw_pkg::req_t r;
    r.is_write = 1'($urandom_range(1));
    r.force_unit_access = 1'($urandom_range(1));
    r.disable_page_out = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: begin
        r.start_lba = $urandom;
        r.block_count = $urandom;
      end
      1: begin
        r.start_lba = corner_value();
        r.block_count = corner_value();
      end
      default: begin
        r.start_lba = $urandom;
        r.block_count = $urandom;
        if (len == scsirw_pkg::LEN_6) begin
          r.start_lba = $urandom_range(32'h1fffff);
          r.block_count = $urandom_range(256);
          if ($urandom_range(9) != 0) begin
            r.force_unit_access = 1'b0;
            r.disable_page_out = 1'b0;
          end
        end else if (len == scsirw_pkg::LEN_10) begin
          r.block_count = $urandom_range(32'hffff);
        end
      end
    endcase
    return r;
  endfunction

  task automatic queue_req(logic [31:0] lba, logic [31:0] cnt, logic wr, logic fua, logic dpo);
    scsirw_pkg::req_t r;
    r.start_lba = lba;
    r.block_count = cnt;
    r.is_write = wr;
    r.force_unit_access = fua;
    r.disable_page_out = dpo;
    req_backlog.push_back(r);
    n_queued++;
  endtask

  task automatic note_fail(string msg);
    n_err++;
    if (n_err <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || cdb_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_length(logic [4:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.command_length <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cmd_len = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // request driver
  always @(negedge clk) begin
    scsirw_pkg::req_t nxt;
    if (!req_ch.valid || req_fire) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = req_backlog.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.start_lba <= nxt.start_lba;
        req_ch.block_count <= nxt.block_count;
        req_ch.is_write <= nxt.is_write;
        req_ch.force_unit_access <= nxt.force_unit_access;
        req_ch.disable_page_out <= nxt.disable_page_out;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (rx_hold) cdb_ch.ready <= 1'b0;
    else cdb_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // long receiver stall while requests keep coming
  initial begin
    wait (stall_go);
    rx_hold = 1'b1;
    repeat (120) @(posedge clk);
    rx_hold = 1'b0;
  end

  // monitor and checker
  always @(posedge clk) begin
    scsirw_pkg::req_t     got_req;
    scsirw_pkg::cdb_res_t want;
    req_fire = (req_ch.valid === 1'b1) && (req_ch.ready === 1'b1);
    if (req_fire) begin
      got_req.start_lba = req_ch.start_lba;
      got_req.block_count = req_ch.block_count;
      got_req.is_write = req_ch.is_write;
      got_req.force_unit_access = req_ch.force_unit_access;
      got_req.disable_page_out = req_ch.disable_page_out;
      cdb_due.push_back(build_cdb(got_req, cmd_len));
      n_accepted++;
    end
    if (rst_n && cdb_ch.valid === 1'b1 && cdb_ch.ready === 1'b1) begin
      if (cdb_due.size() == 0) begin
        note_fail("command block beat with nothing outstanding");
      end else begin
        want = cdb_due.pop_front();
        if (cdb_ch.cdb_low_bytes !== want.cdb_low_bytes)
          note_fail($sformatf("cdb_low_bytes: expected %h, got %h",
                              want.cdb_low_bytes, cdb_ch.cdb_low_bytes));
        if (cdb_ch.cdb_high_bytes !== want.cdb_high_bytes)
          note_fail($sformatf("cdb_high_bytes: expected %h, got %h",
                              want.cdb_high_bytes, cdb_ch.cdb_high_bytes));
        if (cdb_ch.cdb_length !== want.cdb_length)
          note_fail($sformatf("cdb_length: expected %0d, got %0d",
                              want.cdb_length, cdb_ch.cdb_length));
        if (cdb_ch.error_code !== want.error_code)
          note_fail($sformatf("error_code: expected %0d, got %0d",
                              want.error_code, cdb_ch.error_code));
      end
    end
  end

  initial begin
    #200000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [4:0] phase_len [12];
    phase_len = '{scsirw_pkg::LEN_RESET, scsirw_pkg::LEN_6, scsirw_pkg::LEN_16,
                  scsirw_pkg::LEN_12, 5'd0, scsirw_pkg::LEN_6, 5'd31, scsirw_pkg::LEN_10,
                  scsirw_pkg::LEN_16, scsirw_pkg::LEN_6, scsirw_pkg::LEN_12, 5'd7};
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.start_lba = '0;
    req_ch.block_count = '0;
    req_ch.is_write = 1'b0;
    req_ch.force_unit_access = 1'b0;
    req_ch.disable_page_out = 1'b0;
    cdb_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.command_length = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 12; ph++) begin
      wait_drained();
      repeat (3) @(negedge clk);
      if (ph != 0) write_length(phase_len[ph]);
      @(posedge clk);
      tx_idle_pct = (ph < 4) ? 21 : (ph < 8) ? 71 : 0;
      rx_idle_pct = (ph < 4) ? 71 : (ph < 8) ? 21 : 0;

      case (ph)
        0: begin
          queue_req(32'h0, 32'h0, 1'b0, 1'b0, 1'b0);
          queue_req(32'hffffffff, 32'hffff, 1'b1, 1'b1, 1'b1);
          queue_req(32'h12345678, 32'h10000, 1'b0, 1'b1, 1'b0);
          queue_req(32'h87654321, 32'h0001, 1'b1, 1'b0, 1'b1);
        end
        1: begin
          // count of 256 coded as zero, then the 6-byte refusals in priority order
          queue_req(32'h0, 32'd256, 1'b0, 1'b0, 1'b0);
          queue_req(32'h0, 32'd257, 1'b1, 1'b0, 1'b0);
          queue_req(32'h1fffff, 32'd1, 1'b1, 1'b0, 1'b0);
          queue_req(32'h1fffff, 32'd0, 1'b0, 1'b0, 1'b0);
          queue_req(32'h1fffff, 32'd2, 1'b0, 1'b0, 1'b0);
          queue_req(32'hffffffff, 32'd0, 1'b1, 1'b0, 1'b0);
          queue_req(32'h1000, 32'd8, 1'b0, 1'b1, 1'b0);
          queue_req(32'h1000, 32'd8, 1'b1, 1'b0, 1'b1);
          queue_req(32'hffffffff, 32'hffffffff, 1'b1, 1'b1, 1'b1);
          queue_req(32'h200000, 32'd0, 1'b0, 1'b1, 1'b0);
          queue_req(32'h1fff00, 32'd256, 1'b1, 1'b0, 1'b0);
        end
        2: begin
          queue_req(32'hffffffff, 32'hffffffff, 1'b1, 1'b1, 1'b1);
          queue_req(32'h0, 32'h0, 1'b0, 1'b0, 1'b0);
        end
        3: queue_req(32'hdeadbeef, 32'hffffffff, 1'b0, 1'b1, 1'b1);
        4: queue_req(32'h1, 32'h1, 1'b1, 1'b0, 1'b0);
        default: ;
      endcase

      for (int k = 0; k < 48; k++) req_backlog.push_back(random_req(phase_len[ph]));
      n_queued += 48;

      if (ph == 9) stall_go = 1'b1;
    end

    wait_drained();
    repeat (6) @(negedge clk);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/scsirw_pkg.sv
src/scsirw_if.sv
src/scsirw_encode.sv
src/scsi_rw_command_block_builder.sv
test/testbench.sv
